@@ src/assert_macros.svh @@
// assertion macros used by the cycle detector engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define DCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dcd_pkg.sv @@
// shared types and constants of the directed cycle detector
package dcd_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;
  localparam int NV_W         = 7;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic       OP_ADD_EDGE = 1'b0;
  localparam logic       OP_EVALUATE = 1'b1;
  localparam logic       REG_NUM_VERTICES = 1'b0;
  localparam logic [NV_W-1:0] NUM_VERTICES_RST = NV_W'(64);

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VTX_W-1:0]        vtx_t;

  // adjacency memory request
  typedef struct packed {
    logic re;
    vtx_t raddr;
    logic we;
    vtx_t waddr;
    row_t wdata;
  } adj_req_t;

  // search stack memory request
  typedef struct packed {
    logic re;
    vtx_t raddr;
    logic we;
    vtx_t waddr;
    vtx_t wdata;
  } stk_req_t;

  // evaluation result toward the output register
  typedef struct packed {
    logic valid;
    logic has_cycle;
    logic edge_dropped;
  } res_t;

  // lowest set bit of a row
  function automatic vtx_t first_set(input row_t v);
    vtx_t idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) idx = VTX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/dcd_ram.sv @@
// generic single-write, single-read ram with registered read data
module dcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/dcd_engine.sv @@
// sequencer for edge loads and the stack-based depth-first search
module dcd_engine
  import dcd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  input  logic [5:0]      in_src_vertex,
  input  logic [5:0]      in_dest_vertex,
  output logic            in_stall,
  input  logic [NV_W-1:0] num_vertices,
  input  logic            out_free,
  input  row_t            adj_rdata,
  input  vtx_t            stk_rdata,
  output adj_req_t        adj_req,
  output stk_req_t        stk_req,
  output res_t            res
);

`include "assert_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EDGE   = 6'b000010,
    S_ROOT   = 6'b000100,
    S_EXPAND = 6'b001000,
    S_POPRD  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  row_t             visited_r, visited_nxt;
  row_t             on_stack_r, on_stack_nxt;
  row_t             row_valid_r, row_valid_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] root_r, root_nxt;
  vtx_t             top_r, top_nxt;
  vtx_t             dst_r, dst_nxt;
  logic             dropped_r, dropped_nxt;
  logic             cycle_r, cycle_nxt;

  logic [CNT_W-1:0] n_eff;
  row_t             col_mask;
  row_t             row;
  row_t             cand;
  logic             back_edge;
  vtx_t             next_vtx;
  logic             out_range;

  // vertex count, saturated to the matrix size
  always_comb begin
    if (CNT_W'(num_vertices) > CNT_W'(MAX_VERTICES)) n_eff = CNT_W'(MAX_VERTICES);
    else n_eff = CNT_W'(num_vertices);
  end

  // columns below the vertex count
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      col_mask[i] = (CNT_W'(i) < n_eff);
    end
  end

  // current row of the top vertex and its candidate neighbors
  assign row       = (row_valid_r[top_r] ? adj_rdata : '0) & col_mask;
  assign back_edge = |(row & on_stack_r);
  assign cand      = row & ~visited_r;
  assign next_vtx  = first_set(cand);
  assign out_range = ({1'b0, in_src_vertex} >= n_eff) || ({1'b0, in_dest_vertex} >= n_eff);

  assign in_stall = (state_r != S_IDLE);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    on_stack_nxt  = on_stack_r;
    row_valid_nxt = row_valid_r;
    sp_nxt        = sp_r;
    root_nxt      = root_r;
    top_nxt       = top_r;
    dst_nxt       = dst_r;
    dropped_nxt   = dropped_r;
    cycle_nxt     = cycle_r;
    adj_req       = '0;
    stk_req       = '0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_EVALUATE) begin
            root_nxt  = '0;
            cycle_nxt = 1'b0;
            state_nxt = S_ROOT;
          end else if (out_range) begin
            dropped_nxt = 1'b1;
          end else begin
            adj_req.re    = 1'b1;
            adj_req.raddr = in_src_vertex;
            top_nxt       = in_src_vertex;
            dst_nxt       = in_dest_vertex;
            state_nxt     = S_EDGE;
          end
        end
      end

      // read-modify-write of the source row
      S_EDGE: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = top_r;
        adj_req.wdata = (row_valid_r[top_r] ? adj_rdata : '0);
        adj_req.wdata[dst_r] = 1'b1;
        row_valid_nxt[top_r] = 1'b1;
        state_nxt     = S_IDLE;
      end

      // pick the next unvisited start vertex
      S_ROOT: begin
        if (root_r >= n_eff) begin
          state_nxt = S_FIN;
        end else if (visited_r[root_r[VTX_W-1:0]]) begin
          root_nxt = root_r + 1'b1;
        end else begin
          stk_req.we    = 1'b1;
          stk_req.waddr = sp_r[VTX_W-1:0];
          stk_req.wdata = root_r[VTX_W-1:0];
          sp_nxt        = sp_r + 1'b1;
          visited_nxt[root_r[VTX_W-1:0]]  = 1'b1;
          on_stack_nxt[root_r[VTX_W-1:0]] = 1'b1;
          top_nxt       = root_r[VTX_W-1:0];
          adj_req.re    = 1'b1;
          adj_req.raddr = root_r[VTX_W-1:0];
          state_nxt     = S_EXPAND;
        end
      end

      // scan the top row: back edge, push a new vertex, or pop
      S_EXPAND: begin
        if (back_edge) begin
          cycle_nxt = 1'b1;
          state_nxt = S_FIN;
        end else if (|cand) begin
          stk_req.we    = 1'b1;
          stk_req.waddr = sp_r[VTX_W-1:0];
          stk_req.wdata = next_vtx;
          sp_nxt        = sp_r + 1'b1;
          visited_nxt[next_vtx]  = 1'b1;
          on_stack_nxt[next_vtx] = 1'b1;
          top_nxt       = next_vtx;
          adj_req.re    = 1'b1;
          adj_req.raddr = next_vtx;
        end else begin
          on_stack_nxt[top_r] = 1'b0;
          sp_nxt = sp_r - 1'b1;
          if (sp_r == CNT_W'(1)) begin
            state_nxt = S_ROOT;
          end else begin
            stk_req.re    = 1'b1;
            stk_req.raddr = VTX_W'(sp_r - CNT_W'(2));
            state_nxt     = S_POPRD;
          end
        end
      end

      // new top arrives from the stack, fetch its row
      S_POPRD: begin
        top_nxt       = stk_rdata;
        adj_req.re    = 1'b1;
        adj_req.raddr = stk_rdata;
        state_nxt     = S_EXPAND;
      end

      // hand over the result and clear for the next graph
      S_FIN: begin
        if (out_free) begin
          res.valid        = 1'b1;
          res.has_cycle    = cycle_r;
          res.edge_dropped = dropped_r;
          visited_nxt      = '0;
          on_stack_nxt     = '0;
          row_valid_nxt    = '0;
          sp_nxt           = '0;
          dropped_nxt      = 1'b0;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      visited_r   <= '0;
      on_stack_r  <= '0;
      row_valid_r <= '0;
      sp_r        <= '0;
      dropped_r   <= 1'b0;
      cycle_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      on_stack_r  <= on_stack_nxt;
      row_valid_r <= row_valid_nxt;
      sp_r        <= sp_nxt;
      dropped_r   <= dropped_nxt;
      cycle_r     <= cycle_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    top_r  <= top_nxt;
    dst_r  <= dst_nxt;
  end

  `DCD_ASSERT(a_on_stack_visited, (on_stack_r & ~visited_r) == '0, "on-stack vertex not visited")
  `DCD_ASSERT(a_sp_bound, sp_r <= CNT_W'(MAX_VERTICES), "stack pointer beyond depth")
  `DCD_ASSERT_NEXT(a_clear_after_eval, res.valid,
                   visited_r == '0 && sp_r == '0 && row_valid_r == '0 && !dropped_r,
                   "state not cleared after evaluation")

endmodule

@@ src/directed_cycle_detector_unit.sv @@
// Directed cycle detector: adjacency rows and the search stack kept in RAM.
// Edge load: row read, then row write back; a dropped edge only sets the dropped flag.
// Evaluate: accept, then each push, each pop (with a stack read unless it empties the stack),
// each start vertex found visited, and the finish; the result is then registered at the output.
// Reset clears control state and row valid bits at once; no clearing pass.
module directed_cycle_detector_unit
  import dcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [5:0]            in_src_vertex,
  input  logic [5:0]            in_dest_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_cycle,
  output logic                  out_edge_dropped,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [NV_W-1:0] num_vertices_r;
  logic            out_valid_r, out_valid_nxt;
  logic            has_cycle_r, edge_dropped_r;
  logic            out_free;
  adj_req_t        adj_req;
  stk_req_t        stk_req;
  row_t            adj_rdata;
  vtx_t            stk_rdata;
  res_t            res;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= NUM_VERTICES_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_NUM_VERTICES) begin
      num_vertices_r <= cfg_pwdata[NV_W-1:0];
    end
  end

  // register read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_NUM_VERTICES) begin
      cfg_prdata = CFG_DATA_W'(num_vertices_r);
    end
  end

  // output register
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      has_cycle_r    <= res.has_cycle;
      edge_dropped_r <= res.edge_dropped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_cycle    = has_cycle_r;
  assign out_edge_dropped = edge_dropped_r;

  // search sequencer
  dcd_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_op          (in_op),
    .in_src_vertex  (in_src_vertex),
    .in_dest_vertex (in_dest_vertex),
    .in_stall       (in_stall),
    .num_vertices   (num_vertices_r),
    .out_free       (out_free),
    .adj_rdata      (adj_rdata),
    .stk_rdata      (stk_rdata),
    .adj_req        (adj_req),
    .stk_req        (stk_req),
    .res            (res)
  );

  // adjacency rows
  dcd_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_req.we),
    .waddr (adj_req.waddr),
    .wdata (adj_req.wdata),
    .re    (adj_req.re),
    .raddr (adj_req.raddr),
    .rdata (adj_rdata)
  );

  // search stack
  dcd_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

endmodule
